// ===== hdl/cbg_pkg.sv =====
// Package for the circuit breaker gate: field widths, codes for actions, breaker
// modes, status, register indexes, sequencer states and reset values. No dependencies.
`timescale 1ns / 1ps

package cbg_pkg;

  // Field widths fixed by the item format
  localparam int ACTION_W = 2;
  localparam int TIME_W   = 32;
  localparam int COUNT_W  = 16;
  localparam int LIMIT_W  = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ACQUIRE = 2'd0,
    ACT_SUCCESS = 2'd1,
    ACT_FAILURE = 2'd2,
    ACT_RESET   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    MODE_CLOSED = 2'd0,
    MODE_OPEN   = 2'd1,
    MODE_HALF   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OPEN    = 2'd1,
    ST_PROBE   = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FAILURE_THRESHOLD = 3'd0,
    CFG_SUCCESS_THRESHOLD = 3'd1,
    CFG_PROBE_LIMIT       = 3'd2,
    CFG_OPEN_HOLD_TIME    = 3'd3,
    CFG_PROBE_LIFETIME    = 3'd4
  } cfg_index_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_HOLD,
    S_READ,
    S_ELAPSED,
    S_EXPIRE,
    S_DECIDE,
    S_DONE
  } state_t;

  // Register reset values
  localparam logic [COUNT_W-1:0] FAILURE_THRESHOLD_RST = 16'd5;
  localparam logic [COUNT_W-1:0] SUCCESS_THRESHOLD_RST = 16'd1;
  localparam logic [LIMIT_W-1:0] PROBE_LIMIT_RST       = 4'd1;
  localparam logic [TIME_W-1:0]  OPEN_HOLD_TIME_RST    = 32'd1000;
  localparam logic [TIME_W-1:0]  PROBE_LIFETIME_RST    = 32'd1000;

endpackage

// ===== hdl/cbg_if.sv =====
// Valid/ready channel interfaces for the circuit breaker gate: command word
// in, result word out. Depends on cbg_pkg for field widths.
`timescale 1ns / 1ps

interface cbg_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [cbg_pkg::ACTION_W-1:0] action;
  logic [cbg_pkg::TIME_W-1:0]   now;

  modport source (output valid, output action, output now, input ready);
  modport sink   (input valid, input action, input now, output ready);
endinterface

interface cbg_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        allowed;
  logic [1:0]                  mode;
  logic [cbg_pkg::TIME_W-1:0]  retry_after;
  logic [1:0]                  status;
  logic [cbg_pkg::COUNT_W-1:0] failure_count;

  modport source (output valid, output allowed, output mode, output retry_after,
                  output status, output failure_count, input ready);
  modport sink   (input valid, input allowed, input mode, input retry_after,
                  input status, input failure_count, output ready);
endinterface

// ===== hdl/circuit_breaker_gate.sv =====
// Circuit breaker gate top level: sequencer, breaker state, probe ring memory
// and one shared 32-bit subtract/compare unit. Depends on cbg_pkg, cbg_if.
`timescale 1ns / 1ps

// Three-state breaker (closed, open, half-open) driven by one command word at a
// time; each command yields exactly one result word. A word is taken only while
// the sequencer is idle, even if the previous result is still waiting on rsp.
// Commands that finish in the dispatch step (closed state, open-state reports,
// invalid configuration, resets) go straight to the result; a refused open acquire
// passes the hold check first, and half-open work walks the probe timestamp ring,
// retiring up to PROBE_DEPTH expired probes. In that walk one memory read port and
// the single shared subtractor handle one stored timestamp at a time, through the
// read, elapsed and expire steps. A stalled result holds the sequencer in its done
// step until the output register is free.
// Configuration writes are taken at any time but must only be issued while idle.
module circuit_breaker_gate #(
  parameter int PROBE_DEPTH = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [cbg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cbg_pkg::CFG_DATA_W-1:0]  cfg_data,
  cbg_cmd_if.sink                         cmd,
  cbg_rsp_if.source                       rsp
);

  localparam int IDX_W = (PROBE_DEPTH > 1) ? $clog2(PROBE_DEPTH) : 1;
  localparam int CNT_W = $clog2(PROBE_DEPTH + 1);
  localparam int SUM_W = IDX_W + 1;
  localparam int CMP_W = (CNT_W > cbg_pkg::LIMIT_W) ? CNT_W : cbg_pkg::LIMIT_W;
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(PROBE_DEPTH - 1);
  localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(PROBE_DEPTH);
  localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(PROBE_DEPTH);

  localparam int TW = cbg_pkg::TIME_W;
  localparam int CW = cbg_pkg::COUNT_W;

  // Configuration registers
  logic [CW-1:0]                failure_threshold;
  logic [CW-1:0]                success_threshold;
  logic [cbg_pkg::LIMIT_W-1:0]  probe_limit;
  logic [TW-1:0]                open_hold_time;
  logic [TW-1:0]                probe_lifetime;

  always_ff @(posedge clk) begin
    if (rst) begin
      failure_threshold <= cbg_pkg::FAILURE_THRESHOLD_RST;
      success_threshold <= cbg_pkg::SUCCESS_THRESHOLD_RST;
      probe_limit       <= cbg_pkg::PROBE_LIMIT_RST;
      open_hold_time    <= cbg_pkg::OPEN_HOLD_TIME_RST;
      probe_lifetime    <= cbg_pkg::PROBE_LIFETIME_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cbg_pkg::CFG_FAILURE_THRESHOLD: failure_threshold <= cfg_data[CW-1:0];
        cbg_pkg::CFG_SUCCESS_THRESHOLD: success_threshold <= cfg_data[CW-1:0];
        cbg_pkg::CFG_PROBE_LIMIT:       probe_limit <= cfg_data[cbg_pkg::LIMIT_W-1:0];
        cbg_pkg::CFG_OPEN_HOLD_TIME:    open_hold_time <= cfg_data[TW-1:0];
        cbg_pkg::CFG_PROBE_LIFETIME:    probe_lifetime <= cfg_data[TW-1:0];
        default: ;
      endcase
    end
  end

  logic cfg_ok;
  assign cfg_ok = (failure_threshold != '0) && (success_threshold != '0) &&
                  (probe_limit != '0) && (open_hold_time != '0) &&
                  (probe_lifetime != '0);

  // Effective probe limit: smaller of register and ring depth
  logic [CMP_W-1:0] limit_ext;
  logic [CMP_W-1:0] eff_limit;
  assign limit_ext = CMP_W'(probe_limit);
  assign eff_limit = (limit_ext < DEPTH_CMP) ? limit_ext : DEPTH_CMP;

  // Sequencer and breaker state
  cbg_pkg::state_t  state, state_next;
  cbg_pkg::action_t cur_action, cur_action_next;
  logic [TW-1:0]    cur_now, cur_now_next;
  cbg_pkg::mode_t   breaker_mode, breaker_mode_next;
  logic [TW-1:0]    opened_time, opened_time_next;
  logic [CW-1:0]    fail_run, fail_run_next;
  logic [CW-1:0]    success_run, success_run_next;
  logic [IDX_W-1:0] probe_head, probe_head_next;
  logic [CNT_W-1:0] probe_count, probe_count_next;
  logic [TW-1:0]    elapsed, elapsed_next;

  // Result being built, and the output register
  logic             res_allowed, res_allowed_next;
  logic [TW-1:0]    res_retry, res_retry_next;
  cbg_pkg::status_t res_status, res_status_next;
  logic             out_valid, out_valid_next;
  logic             out_allowed, out_allowed_next;
  cbg_pkg::mode_t   out_mode, out_mode_next;
  logic [TW-1:0]    out_retry, out_retry_next;
  cbg_pkg::status_t out_status, out_status_next;
  logic [CW-1:0]    out_fail, out_fail_next;

  // Probe ring memory
  logic [TW-1:0]    probe_mem [PROBE_DEPTH];
  logic [TW-1:0]    rd_data;
  logic             mem_we;
  logic [SUM_W-1:0] wr_sum;
  logic [IDX_W-1:0] wr_addr;

  assign wr_sum  = SUM_W'(probe_head) + SUM_W'(probe_count);
  assign wr_addr = (wr_sum >= DEPTH_SUM) ? IDX_W'(wr_sum - DEPTH_SUM) : IDX_W'(wr_sum);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      probe_mem[wr_addr] <= cur_now;
    end
    rd_data <= probe_mem[probe_head];
  end

  // Shared subtract/compare unit: diff = a - b, a_gt_b when a > b
  logic [TW-1:0] sub_a, sub_b, sub_diff;
  logic [TW:0]   sub_full;
  logic          a_gt_b;

  always_comb begin
    unique case (state)
      cbg_pkg::S_CHECK: begin
        sub_a = cur_now;
        sub_b = opened_time;
      end
      cbg_pkg::S_ELAPSED: begin
        sub_a = cur_now;
        sub_b = rd_data;
      end
      cbg_pkg::S_HOLD: begin
        sub_a = open_hold_time;
        sub_b = elapsed;
      end
      default: begin
        sub_a = probe_lifetime;
        sub_b = elapsed;
      end
    endcase
  end

  assign sub_full = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_diff = sub_full[TW-1:0];
  assign a_gt_b   = !sub_full[TW] && (sub_diff != '0);

  // Saturating counter increments and probe bookkeeping
  logic [CW-1:0]    fail_inc, success_inc;
  logic [IDX_W-1:0] head_adv;
  logic             ring_full;

  assign fail_inc    = (fail_run == '1) ? fail_run : fail_run + 1'b1;
  assign success_inc = (success_run == '1) ? success_run : success_run + 1'b1;
  assign head_adv    = (probe_head == LAST_IDX) ? '0 : probe_head + 1'b1;
  assign ring_full   = CMP_W'(probe_count) >= eff_limit;

  assign cmd.ready = (state == cbg_pkg::S_IDLE);

  // Next state and datapath
  always_comb begin
    state_next        = state;
    cur_action_next   = cur_action;
    cur_now_next      = cur_now;
    breaker_mode_next = breaker_mode;
    opened_time_next  = opened_time;
    fail_run_next     = fail_run;
    success_run_next  = success_run;
    probe_head_next   = probe_head;
    probe_count_next  = probe_count;
    elapsed_next      = elapsed;
    res_allowed_next  = res_allowed;
    res_retry_next    = res_retry;
    res_status_next   = res_status;
    out_valid_next    = out_valid && !rsp.ready;
    out_allowed_next  = out_allowed;
    out_mode_next     = out_mode;
    out_retry_next    = out_retry;
    out_status_next   = out_status;
    out_fail_next     = out_fail;
    mem_we            = 1'b0;

    unique case (state)
      cbg_pkg::S_IDLE: begin
        if (cmd.valid) begin
          cur_action_next  = cbg_pkg::action_t'(cmd.action);
          cur_now_next     = cmd.now;
          res_allowed_next = 1'b0;
          res_retry_next   = '0;
          res_status_next  = cbg_pkg::ST_OK;
          state_next       = cbg_pkg::S_CHECK;
        end
      end

      // Dispatch on action and mode
      cbg_pkg::S_CHECK: begin
        state_next = cbg_pkg::S_DONE;
        unique case (cur_action)
          cbg_pkg::ACT_ACQUIRE: begin
            if (!cfg_ok) begin
              res_status_next = cbg_pkg::ST_INVALID;
            end else if (breaker_mode == cbg_pkg::MODE_OPEN) begin
              elapsed_next = sub_diff;
              state_next   = cbg_pkg::S_HOLD;
            end else if (breaker_mode == cbg_pkg::MODE_HALF) begin
              state_next = cbg_pkg::S_READ;
            end else begin
              res_allowed_next = 1'b1;
            end
          end
          cbg_pkg::ACT_SUCCESS: begin
            if (breaker_mode != cbg_pkg::MODE_OPEN) begin
              fail_run_next = '0;
              if (breaker_mode == cbg_pkg::MODE_HALF) begin
                state_next = cbg_pkg::S_READ;
              end else begin
                success_run_next = '0;
              end
            end
          end
          cbg_pkg::ACT_FAILURE: begin
            if (breaker_mode == cbg_pkg::MODE_HALF) begin
              state_next = cbg_pkg::S_READ;
            end else if (breaker_mode != cbg_pkg::MODE_OPEN) begin
              fail_run_next = fail_inc;
              if (fail_inc >= failure_threshold) begin
                breaker_mode_next = cbg_pkg::MODE_OPEN;
                opened_time_next  = cur_now;
                fail_run_next     = '0;
                success_run_next  = '0;
                probe_head_next   = '0;
                probe_count_next  = '0;
              end
            end
          end
          default: begin
            breaker_mode_next = cbg_pkg::MODE_CLOSED;
            opened_time_next  = '0;
            fail_run_next     = '0;
            success_run_next  = '0;
            probe_head_next   = '0;
            probe_count_next  = '0;
          end
        endcase
      end

      // Open: refuse while hold time remains, else go half-open
      cbg_pkg::S_HOLD: begin
        if (a_gt_b) begin
          res_retry_next  = sub_diff;
          res_status_next = cbg_pkg::ST_OPEN;
          state_next      = cbg_pkg::S_DONE;
        end else begin
          breaker_mode_next = cbg_pkg::MODE_HALF;
          fail_run_next     = '0;
          success_run_next  = '0;
          probe_head_next   = '0;
          probe_count_next  = '0;
          state_next        = cbg_pkg::S_READ;
        end
      end

      // Oldest probe timestamp is read from the ring here
      cbg_pkg::S_READ: begin
        state_next = (probe_count == '0) ? cbg_pkg::S_DECIDE : cbg_pkg::S_ELAPSED;
      end

      cbg_pkg::S_ELAPSED: begin
        elapsed_next = sub_diff;
        state_next   = cbg_pkg::S_EXPIRE;
      end

      // Retire the oldest probe if its lifetime is used up
      cbg_pkg::S_EXPIRE: begin
        if (!a_gt_b) begin
          probe_head_next  = head_adv;
          probe_count_next = probe_count - 1'b1;
          state_next       = cbg_pkg::S_READ;
        end else begin
          state_next = cbg_pkg::S_DECIDE;
        end
      end

      // Half-open decision on live probes
      cbg_pkg::S_DECIDE: begin
        state_next = cbg_pkg::S_DONE;
        unique case (cur_action)
          cbg_pkg::ACT_ACQUIRE: begin
            if (ring_full) begin
              if (probe_count != '0) begin
                res_retry_next = a_gt_b ? sub_diff : '0;
              end
              res_status_next = cbg_pkg::ST_PROBE;
            end else begin
              mem_we           = 1'b1;
              probe_count_next = probe_count + 1'b1;
              res_allowed_next = 1'b1;
            end
          end
          cbg_pkg::ACT_SUCCESS: begin
            if (probe_count != '0) begin
              probe_head_next  = head_adv;
              probe_count_next = probe_count - 1'b1;
              success_run_next = success_inc;
              if (success_inc >= success_threshold) begin
                breaker_mode_next = cbg_pkg::MODE_CLOSED;
                opened_time_next  = '0;
                fail_run_next     = '0;
                success_run_next  = '0;
                probe_head_next   = '0;
                probe_count_next  = '0;
              end
            end
          end
          cbg_pkg::ACT_FAILURE: begin
            if (probe_count != '0) begin
              breaker_mode_next = cbg_pkg::MODE_OPEN;
              opened_time_next  = cur_now;
              fail_run_next     = '0;
              success_run_next  = '0;
              probe_head_next   = '0;
              probe_count_next  = '0;
            end
          end
          default: ;
        endcase
      end

      // Hand the result word to the output register once it is free
      cbg_pkg::S_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next   = 1'b1;
          out_allowed_next = res_allowed;
          out_mode_next    = breaker_mode;
          out_retry_next   = res_retry;
          out_status_next  = res_status;
          out_fail_next    = fail_run;
          state_next       = cbg_pkg::S_IDLE;
        end
      end

      default: state_next = cbg_pkg::S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= cbg_pkg::S_IDLE;
      breaker_mode <= cbg_pkg::MODE_CLOSED;
      opened_time  <= '0;
      fail_run     <= '0;
      success_run  <= '0;
      probe_head   <= '0;
      probe_count  <= '0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      breaker_mode <= breaker_mode_next;
      opened_time  <= opened_time_next;
      fail_run     <= fail_run_next;
      success_run  <= success_run_next;
      probe_head   <= probe_head_next;
      probe_count  <= probe_count_next;
      out_valid    <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_action  <= cur_action_next;
    cur_now     <= cur_now_next;
    elapsed     <= elapsed_next;
    res_allowed <= res_allowed_next;
    res_retry   <= res_retry_next;
    res_status  <= res_status_next;
    out_allowed <= out_allowed_next;
    out_mode    <= out_mode_next;
    out_retry   <= out_retry_next;
    out_status  <= out_status_next;
    out_fail    <= out_fail_next;
  end

  assign rsp.valid         = out_valid;
  assign rsp.allowed       = out_allowed;
  assign rsp.mode          = out_mode;
  assign rsp.retry_after   = out_retry;
  assign rsp.status        = out_status;
  assign rsp.failure_count = out_fail;

`ifndef SYNTHESIS
  // Ring never holds more probes than it has entries
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(probe_count) <= PROBE_DEPTH)
    else $error("probe count exceeds ring depth");

  // Probes exist only in half-open mode
  a_probes_half: assert property (@(posedge clk) disable iff (rst)
    (state == cbg_pkg::S_IDLE && breaker_mode != cbg_pkg::MODE_HALF) |->
    probe_count == '0)
    else $error("probes outstanding outside half-open");

  // A granted word is never reported from an open breaker
  a_grant_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_allowed) |->
    (out_status == cbg_pkg::ST_OK && out_mode != cbg_pkg::MODE_OPEN))
    else $error("grant with bad status or open mode");

  // An open refusal carries a nonzero wait and an open mode
  a_open_refuse: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status == cbg_pkg::ST_OPEN) |->
    (out_retry != '0 && out_mode == cbg_pkg::MODE_OPEN && !out_allowed))
    else $error("open refusal malformed");

  // A new result word is loaded only when the previous one was taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsp.ready) |=> $stable(out_retry) && out_valid)
    else $error("result word overwritten while stalled");
`endif

endmodule

// ===== bench/circuit_breaker_gate_test.sv =====
// Self-checking bench for circuit_breaker_gate: directed and random command words,
// checked against a breaker scoreboard. Depends on cbg_pkg, cbg_if and the RTL.
`timescale 1ns / 1ps

module circuit_breaker_gate_test;

  localparam int RING_DEPTH  = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 12;
  localparam int PHASE_WORDS = 120;

  // Expected result word
  typedef struct {
    logic             allowed;
    cbg_pkg::mode_t   mode;
    logic [31:0]      retry;
    cbg_pkg::status_t status;
    logic [15:0]      fails;
  } verdict_t;

  // Breaker scoreboard: mirrors registers and breaker state, queues verdicts
  class breaker_scoreboard;
    logic [15:0] fail_limit;
    logic [15:0] win_limit;
    logic [3:0]  probe_cap;
    logic [31:0] hold_ticks;
    logic [31:0] probe_ttl;

    cbg_pkg::mode_t brk_mode;
    logic [31:0] opened_at;
    logic [15:0] fail_run;
    logic [15:0] win_run;
    logic [31:0] probe_ring [RING_DEPTH];
    int unsigned ring_head;
    int unsigned ring_count;

    verdict_t    pending_verdicts [$];
    int          results_seen;
    int          errors;

    function new();
      fail_limit = cbg_pkg::FAILURE_THRESHOLD_RST;
      win_limit  = cbg_pkg::SUCCESS_THRESHOLD_RST;
      probe_cap  = cbg_pkg::PROBE_LIMIT_RST;
      hold_ticks = cbg_pkg::OPEN_HOLD_TIME_RST;
      probe_ttl  = cbg_pkg::PROBE_LIFETIME_RST;
      foreach (probe_ring[i]) probe_ring[i] = '0;
      results_seen = 0;
      errors = 0;
      close_breaker();
    endfunction

    function void write_register(cbg_pkg::cfg_index_t idx, logic [31:0] value);
      case (idx)
        cbg_pkg::CFG_FAILURE_THRESHOLD: fail_limit = value[15:0];
        cbg_pkg::CFG_SUCCESS_THRESHOLD: win_limit  = value[15:0];
        cbg_pkg::CFG_PROBE_LIMIT:       probe_cap  = value[3:0];
        cbg_pkg::CFG_OPEN_HOLD_TIME:    hold_ticks = value;
        cbg_pkg::CFG_PROBE_LIFETIME:    probe_ttl  = value;
        default: ;
      endcase
    endfunction

    function int pending_count();
      return pending_verdicts.size();
    endfunction

    function void clear_probes();
      ring_head  = 0;
      ring_count = 0;
    endfunction

    function void open_breaker(logic [31:0] t);
      brk_mode  = cbg_pkg::MODE_OPEN;
      opened_at = t;
      fail_run  = '0;
      win_run   = '0;
      clear_probes();
    endfunction

    function void close_breaker();
      brk_mode  = cbg_pkg::MODE_CLOSED;
      opened_at = '0;
      fail_run  = '0;
      win_run   = '0;
      clear_probes();
    endfunction

    function void enter_half();
      brk_mode = cbg_pkg::MODE_HALF;
      fail_run = '0;
      win_run  = '0;
      clear_probes();
    endfunction

    function void pop_probe();
      if (ring_count > 0) begin
        ring_head  = (ring_head + 1) % RING_DEPTH;
        ring_count = ring_count - 1;
      end
    endfunction

    // Drop probes from the head of the ring once their lifetime has run out
    function void retire_stale(logic [31:0] t);
      logic [31:0] age;
      while (ring_count > 0) begin
        age = t - probe_ring[ring_head];
        if (age < probe_ttl) break;
        pop_probe();
      end
    endfunction

    function logic [15:0] bump(logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // Work out the result of one accepted command word and queue it
    function void note_command(cbg_pkg::action_t act, logic [31:0] t);
      verdict_t    v;
      logic [31:0] age;
      int unsigned lim;
      bit          refused;
      v.allowed = 1'b0;
      v.retry   = '0;
      v.status  = cbg_pkg::ST_OK;
      case (act)
        cbg_pkg::ACT_ACQUIRE: begin
          if (fail_limit == 0 || win_limit == 0 || probe_cap == 0 ||
              hold_ticks == 0 || probe_ttl == 0) begin
            v.status = cbg_pkg::ST_INVALID;
          end else begin
            refused = 1'b0;
            if (brk_mode == cbg_pkg::MODE_OPEN) begin
              age = t - opened_at;
              if (age < hold_ticks) begin
                v.retry  = hold_ticks - age;
                v.status = cbg_pkg::ST_OPEN;
                refused  = 1'b1;
              end else begin
                enter_half();
              end
            end
            if (!refused && brk_mode == cbg_pkg::MODE_HALF) begin
              lim = (probe_cap < RING_DEPTH) ? probe_cap : RING_DEPTH;
              retire_stale(t);
              if (ring_count >= lim) begin
                if (ring_count > 0) begin
                  age = t - probe_ring[ring_head];
                  v.retry = (age >= probe_ttl) ? 32'd0 : probe_ttl - age;
                end
                v.status = cbg_pkg::ST_PROBE;
                refused  = 1'b1;
              end else begin
                probe_ring[(ring_head + ring_count) % RING_DEPTH] = t;
                ring_count = ring_count + 1;
              end
            end
            v.allowed = !refused;
          end
        end
        cbg_pkg::ACT_SUCCESS: begin
          if (brk_mode != cbg_pkg::MODE_OPEN) begin
            fail_run = '0;
            if (brk_mode == cbg_pkg::MODE_HALF) begin
              retire_stale(t);
              if (ring_count > 0) begin
                pop_probe();
                win_run = bump(win_run);
                if (win_run >= win_limit) close_breaker();
              end
            end else begin
              win_run = '0;
            end
          end
        end
        cbg_pkg::ACT_FAILURE: begin
          if (brk_mode == cbg_pkg::MODE_HALF) begin
            retire_stale(t);
            if (ring_count > 0) open_breaker(t);
          end else if (brk_mode != cbg_pkg::MODE_OPEN) begin
            fail_run = bump(fail_run);
            if (fail_run >= fail_limit) open_breaker(t);
          end
        end
        default: close_breaker();
      endcase
      v.mode  = brk_mode;
      v.fails = fail_run;
      pending_verdicts.insert(pending_verdicts.size(), v);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task compare(string field, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("word %0d %s: got %0h, want %0h", results_seen, field, got, want));
    endtask

    // Compare one accepted result word with the oldest verdict
    task check_result(logic got_allowed, logic [1:0] got_mode, logic [31:0] got_retry,
                      logic [1:0] got_status, logic [15:0] got_fails);
      verdict_t want;
      if (pending_verdicts.size() == 0) begin
        report($sformatf("word %0d arrived with nothing outstanding", results_seen));
      end else begin
        want = pending_verdicts[0];
        pending_verdicts.delete(0);
        compare("allowed", 32'(got_allowed), 32'(want.allowed));
        compare("mode", 32'(got_mode), 32'(want.mode));
        compare("retry_after", got_retry, want.retry);
        compare("status", 32'(got_status), 32'(want.status));
        compare("failure_count", 32'(got_fails), 32'(want.fails));
      end
      results_seen++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                           cfg_we;
  logic [cbg_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [cbg_pkg::CFG_DATA_W-1:0] cfg_data;
  logic [31:0]                    tick;
  bit                             calm = 1'b0;
  int                             cycle_count = 0;
  breaker_scoreboard              board;

  cbg_cmd_if cmd_ch ();
  cbg_rsp_if rsp_ch ();

  circuit_breaker_gate #(.PROBE_DEPTH(RING_DEPTH)) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd_ch),
    .rsp       (rsp_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: random stalls, check every accepted word
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready)
        board.check_result(rsp_ch.allowed, rsp_ch.mode, rsp_ch.retry_after,
                           rsp_ch.status, rsp_ch.failure_count);
      rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 24);
    end
  end

  // One register write; the caller lowers the enable after the last one
  task automatic write_one(input cbg_pkg::cfg_index_t idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    board.write_register(idx, value);
  endtask

  task automatic set_config(input logic [31:0] fail_th, input logic [31:0] win_th,
                            input logic [31:0] cap, input logic [31:0] hold,
                            input logic [31:0] ttl);
    write_one(cbg_pkg::CFG_FAILURE_THRESHOLD, fail_th);
    write_one(cbg_pkg::CFG_SUCCESS_THRESHOLD, win_th);
    write_one(cbg_pkg::CFG_PROBE_LIMIT, cap);
    write_one(cbg_pkg::CFG_OPEN_HOLD_TIME, hold);
    write_one(cbg_pkg::CFG_PROBE_LIFETIME, ttl);
    cfg_we <= 1'b0;
  endtask

  // Offer one command word; valid stays high after acceptance unless we idle
  task automatic send_command(input cbg_pkg::action_t act, input logic [31:0] t);
    while (!calm && $urandom_range(0, 99) < 24) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid  <= 1'b1;
    cmd_ch.action <= act;
    cmd_ch.now    <= t;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    board.note_command(act, t);
  endtask

  task automatic step(input cbg_pkg::action_t act, input logic [31:0] delta);
    tick = tick + delta;
    send_command(act, tick);
  endtask

  // Stop offering words and wait until every verdict has been matched
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    while (board.pending_count() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Directed walk through every mode, refusal and report case, across the wrap
  task automatic run_directed();
    set_config(2, 2, 2, 10, 20);
    tick = 32'hFFFF_FFF0;
    step(cbg_pkg::ACT_ACQUIRE, 0);
    step(cbg_pkg::ACT_SUCCESS, 1);
    step(cbg_pkg::ACT_FAILURE, 1);
    step(cbg_pkg::ACT_FAILURE, 1);     // opens
    step(cbg_pkg::ACT_FAILURE, 1);     // ignored while open
    step(cbg_pkg::ACT_SUCCESS, 0);     // ignored while open
    step(cbg_pkg::ACT_ACQUIRE, 2);     // refused, hold time left
    step(cbg_pkg::ACT_ACQUIRE, 7);     // hold expired: half-open, first probe
    step(cbg_pkg::ACT_ACQUIRE, 0);
    step(cbg_pkg::ACT_ACQUIRE, 1);     // refused at the probe limit
    step(cbg_pkg::ACT_SUCCESS, 1);
    step(cbg_pkg::ACT_ACQUIRE, 25);    // old probe expired first
    step(cbg_pkg::ACT_SUCCESS, 30);    // no live probe left
    step(cbg_pkg::ACT_FAILURE, 0);     // no live probe left
    step(cbg_pkg::ACT_ACQUIRE, 0);
    step(cbg_pkg::ACT_SUCCESS, 1);     // reaches the success threshold: closed
    step(cbg_pkg::ACT_FAILURE, 1);
    step(cbg_pkg::ACT_FAILURE, 1);
    step(cbg_pkg::ACT_RESET, 0);
    tick = 32'hFFFF_FFFF;
    step(cbg_pkg::ACT_ACQUIRE, 0);
    drain();
    // zero probe limit makes acquires invalid
    set_config(1, 1, 0, 5, 9);
    step(cbg_pkg::ACT_ACQUIRE, 1);
    drain();
    // limit above ring depth is capped at the depth
    set_config(1, 1, 15, 5, 9);
    step(cbg_pkg::ACT_FAILURE, 1);
    repeat (9) step(cbg_pkg::ACT_ACQUIRE, 5);
  endtask

  // One random phase: new settings, then a run of mixed commands
  task automatic run_phase(input int phase);
    logic [31:0]      span;
    logic [31:0]      delta;
    int               roll;
    cbg_pkg::action_t act;
    drain();
    case (phase)
      0:  set_config(3, 2, 3, 40, 60);
      1:  set_config(1, 1, 8, 1, 1);
      2:  set_config(32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_000F, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF);
      3:  set_config(0, 3, 4, 25, 80);
      4:  set_config(2, 0, 2, 10, 30);
      5:  set_config(2, 2, 0, 10, 30);
      6:  set_config(4, 3, 5, 0, 50);
      7:  set_config(4, 3, 5, 30, 0);
      11: set_config($urandom, $urandom, $urandom, $urandom, $urandom);
      default: set_config($urandom_range(1, 6), $urandom_range(1, 4), $urandom_range(1, 15),
                          $urandom_range(1, 200), $urandom_range(1, 300));
    endcase
    calm = (phase == 9);
    span = (board.hold_ticks < board.probe_ttl) ? board.hold_ticks : board.probe_ttl;
    if (span > 400) span = 400;
    if (span < 2) span = 2;
    repeat (PHASE_WORDS) begin
      roll = $urandom_range(0, 99);
      act = (roll < 45) ? cbg_pkg::ACT_ACQUIRE : (roll < 70) ? cbg_pkg::ACT_SUCCESS :
            (roll < 95) ? cbg_pkg::ACT_FAILURE : cbg_pkg::ACT_RESET;
      roll = $urandom_range(0, 63);
      if (roll == 0) delta = 32'hFFFF_FFFF;
      else if (roll < 3) delta = $urandom;
      else delta = $urandom_range(0, span / 4 + 1);
      step(act, delta);
    end
  endtask

  initial begin
    board = new();
    cmd_ch.valid  = 1'b0;
    cmd_ch.action = cbg_pkg::ACT_ACQUIRE;
    cmd_ch.now    = '0;
    rsp_ch.ready  = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = cbg_pkg::CFG_FAILURE_THRESHOLD;
    cfg_data      = '0;
    tick          = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    for (int p = 0; p < PHASES; p++) run_phase(p);
    drain();
    repeat (40) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
